[design/kmu_pkg.sv]
// Shared types and constants for the k-way merge union block.
package kmu_pkg;

  // Fixed field widths
  localparam int unsigned ID_W  = 32;
  localparam int unsigned SRC_W = 3;
  localparam int unsigned CFG_W = 4;
  localparam int unsigned OUT_W = 40;

  // Number of source lists; the source field addresses all of them
  localparam int unsigned MAX_SOURCES = 8;

  // Sources in use after reset
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  // One held head: a valid flag, the id and the source it came from
  typedef struct packed {
    logic             vld;
    logic [ID_W-1:0]  val;
    logic [SRC_W-1:0] src;
  } entry_t;

  // One result
  typedef struct packed {
    logic             protocol_error;
    logic             done_res;
    logic [SRC_W-1:0] refill_source;
    logic             refill_valid;
    logic [ID_W-1:0]  merged_id;
    logic             emit_valid;
  } res_t;

endpackage

[design/kmu_cell.sv]
// One cell of the sorted head chain: insert, pick first active entry, close the gap.
module kmu_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [kmu_pkg::CFG_W-1:0] cfg_i,
  input  logic                      ins_en_i,
  input  kmu_pkg::entry_t           ins_key_i,
  input  logic                      pop_en_i,
  input  logic                      b_left_i,
  input  kmu_pkg::entry_t           left_q_i,
  input  kmu_pkg::entry_t           right_ins_i,
  input  logic                      found_left_i,
  output logic                      b_o,
  output kmu_pkg::entry_t           q_o,
  output kmu_pkg::entry_t           ins_o,
  output logic                      found_o,
  output logic                      sel_o
);

  kmu_pkg::entry_t entry_q;
  kmu_pkg::entry_t entry_d;
  logic            act;

  // New key goes at or before this place when this entry is empty or larger;
  // ties on value are broken by the lower source index
  assign b_o = ins_en_i &&
               (!entry_q.vld || ({entry_q.val, entry_q.src} > {ins_key_i.val, ins_key_i.src}));

  // Entry after insertion: keep, take the new key, or shift in from the left
  always_comb begin
    if (b_o) begin
      if (b_left_i) begin
        ins_o = left_q_i;
      end else begin
        ins_o     = ins_key_i;
        ins_o.vld = 1'b1;
      end
    end else begin
      ins_o = entry_q;
    end
  end

  // Entry belongs to a source taking part in the merge
  assign act     = ins_o.vld && (({1'b0, ins_o.src} < cfg_i) || (ins_o.src == '0));
  assign sel_o   = act && !found_left_i;
  assign found_o = found_left_i || act;

  // Close the gap left by the consumed head
  assign entry_d = (pop_en_i && found_o) ? right_ins_i : ins_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign q_o = entry_q;

endmodule

[design/kmu_out_buf.sv]
// Result register between the merge logic and the output stream.
module kmu_out_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  kmu_pkg::res_t in_res_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output kmu_pkg::res_t out_res_o
);

  logic          vld_q;
  logic          vld_d;
  kmu_pkg::res_t res_q;

  // Take a new result when empty or when the held one leaves this cycle
  assign in_ready_o = !vld_q || out_ready_i;
  assign vld_d      = in_ready_o ? in_valid_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      res_q <= in_res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign out_res_o   = res_q;

  // A held result stays put until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && !out_ready_i) |=> (vld_q && $stable(res_q)))
    else $error("held result changed before it was taken");

endmodule

[design/kway_merge_union_dedup.sv]
// Top level of the k-way merge of ascending id lists with duplicate removal.
//
//   channel  dir  handshake                   contents
//   s_axis   in   s_axis_tvalid/tready        doc_id, source, list_end
//   m_axis   out  m_axis_tvalid/tready        one result per request
//   cfg      in   cfg_we_i                    sources_in_use
//
// One request is taken per cycle unless a held result is stalled; its result
// is captured in the output register. Insertion into the sorted cell chain,
// selection of the first active head and removal all happen in the accepting
// cycle, so the next request sees the updated state at once.
// Reset clears the valid flags, present/ended bits and the last emitted id.
// A stalled output holds its result; a new request is taken while the held
// result leaves in the same cycle.
module kway_merge_union_dedup (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_we_i,
  input  logic [kmu_pkg::CFG_W-1:0] cfg_wdata_i,
  // input stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [31:0]               s_axis_tdata,   // [31:0] doc_id
  input  logic [2:0]                s_axis_tuser,   // [2:0] source
  input  logic                      s_axis_tlast,   // list_end
  // result stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // [0] emit_valid, [32:1] merged_id, [33] refill_valid, [36:34] refill_source,
  // [37] done_res, [38] protocol_error, [39] zero
  output logic [kmu_pkg::OUT_W-1:0] m_axis_tdata
);

  localparam int unsigned MAX_SOURCES = kmu_pkg::MAX_SOURCES;

  logic [kmu_pkg::CFG_W-1:0] cfg_q;
  logic [MAX_SOURCES-1:0]    present_q, present_d;
  logic [MAX_SOURCES-1:0]    ended_q, ended_d;
  logic [MAX_SOURCES-1:0]    pres_n, end_n, act_src, src_oh, sel_oh;
  logic [kmu_pkg::ID_W-1:0]  last_q, last_d;
  logic                      last_vld_q, last_vld_d;

  logic                      step, src_ok, hit, head_acc, end_acc;
  logic                      ready, all_ended, pop, emit;
  logic [kmu_pkg::ID_W-1:0]  sel_val;
  logic [kmu_pkg::SRC_W-1:0] sel_src;
  kmu_pkg::entry_t           x_key;
  kmu_pkg::res_t             res;
  kmu_pkg::res_t             out_res;

  kmu_pkg::entry_t           q_w   [MAX_SOURCES];
  kmu_pkg::entry_t           ins_w [MAX_SOURCES+1];
  logic [MAX_SOURCES-1:0]    b_w, sel_w, cell_vld;
  logic [MAX_SOURCES:0]      found_w;

  assign step = s_axis_tvalid && s_axis_tready;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= kmu_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // Source decode and request check
  always_comb begin
    for (int i = 0; i < MAX_SOURCES; i++) begin
      act_src[i] = (int'(cfg_q) > i) || (i == 0);
      src_oh[i]  = (int'(s_axis_tuser) == i);
    end
    src_ok   = (int'(s_axis_tuser) < MAX_SOURCES) && (|(src_oh & act_src));
    hit      = |(src_oh & (present_q | ended_q));
    head_acc = step && src_ok && !hit && !s_axis_tlast;
    end_acc  = step && src_ok && !hit && s_axis_tlast;
  end

  // Present/ended after this request, and readiness over active sources
  always_comb begin
    ready     = 1'b1;
    all_ended = 1'b1;
    for (int i = 0; i < MAX_SOURCES; i++) begin
      pres_n[i] = present_q[i] || (head_acc && src_oh[i]);
      end_n[i]  = ended_q[i] || (end_acc && src_oh[i]);
      if (act_src[i] && !pres_n[i] && !end_n[i]) begin
        ready = 1'b0;
      end
      if (act_src[i] && !end_n[i]) begin
        all_ended = 1'b0;
      end
    end
  end

  assign x_key.vld = 1'b1;
  assign x_key.val = s_axis_tdata;
  assign x_key.src = s_axis_tuser;

  assign pop = step && ready && found_w[MAX_SOURCES];

  // Sorted chain of held heads
  assign found_w[0]           = 1'b0;
  assign ins_w[MAX_SOURCES]   = '0;

  for (genvar j = 0; j < MAX_SOURCES; j++) begin : g_cell
    logic            b_left;
    kmu_pkg::entry_t left_q;

    if (j == 0) begin : g_first
      assign b_left = 1'b0;
      assign left_q = '0;
    end else begin : g_rest
      assign b_left = b_w[j-1];
      assign left_q = q_w[j-1];
    end

    kmu_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cfg_i        (cfg_q),
      .ins_en_i     (head_acc),
      .ins_key_i    (x_key),
      .pop_en_i     (pop),
      .b_left_i     (b_left),
      .left_q_i     (left_q),
      .right_ins_i  (ins_w[j+1]),
      .found_left_i (found_w[j]),
      .b_o          (b_w[j]),
      .q_o          (q_w[j]),
      .ins_o        (ins_w[j]),
      .found_o      (found_w[j+1]),
      .sel_o        (sel_w[j])
    );

    assign cell_vld[j] = q_w[j].vld;
  end

  // Pick out the selected head
  always_comb begin
    sel_val = '0;
    sel_src = '0;
    for (int j = 0; j < MAX_SOURCES; j++) begin
      if (sel_w[j]) begin
        sel_val = sel_val | ins_w[j].val;
        sel_src = sel_src | ins_w[j].src;
      end
    end
    for (int i = 0; i < MAX_SOURCES; i++) begin
      sel_oh[i] = (int'(sel_src) == i);
    end
  end

  // Duplicate filter and state update
  assign emit       = pop && (!last_vld_q || (sel_val != last_q));
  assign last_d     = emit ? sel_val : last_q;
  assign last_vld_d = last_vld_q || emit;
  assign present_d  = pres_n & ~({MAX_SOURCES{pop}} & sel_oh);
  assign ended_d    = end_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q  <= '0;
      ended_q    <= '0;
      last_q     <= '0;
      last_vld_q <= 1'b0;
    end else begin
      present_q  <= present_d;
      ended_q    <= ended_d;
      last_q     <= last_d;
      last_vld_q <= last_vld_d;
    end
  end

  // Result
  always_comb begin
    res.emit_valid     = emit;
    res.merged_id      = emit ? sel_val : '0;
    res.refill_valid   = pop;
    res.refill_source  = pop ? sel_src : '0;
    res.done_res       = all_ended;
    res.protocol_error = !(src_ok && !hit);
  end

  kmu_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_res_i    (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (out_res)
  );

  assign m_axis_tdata = {1'b0, out_res};

  // The number of present heads matches the number of occupied cells
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(present_q) == $countones(cell_vld))
    else $error("present bits and chain occupancy disagree");

  // A source never holds a head after it has ended
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (present_q & ended_q) == '0)
    else $error("source both holding a head and ended");

  // The consumed head belongs to a source that holds one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (|(sel_oh & pres_n)))
    else $error("consumed head from a source without one");

  // Chain stays packed and in ascending key order
  for (genvar j = 0; j + 1 < MAX_SOURCES; j++) begin : g_chk
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      q_w[j+1].vld |->
        (q_w[j].vld && ({q_w[j].val, q_w[j].src} < {q_w[j+1].val, q_w[j+1].src})))
      else $error("cell chain out of order");
  end

endmodule
